// File: hdl/sync_length_crc16_deframer_assert.svh
`ifndef SYNC_LENGTH_CRC16_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_CRC16_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcd assertion failed");

`endif

// File: hdl/slcd_pkg.sv
package slcd_pkg;

  localparam logic [7:0]  SYNC1_BYTE = 8'h55;
  localparam logic [7:0]  SYNC2_BYTE = 8'hAA;
  localparam logic [7:0]  CMD_ACK    = 8'h01;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } slcd_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       ack_request;
    logic       last;
  } slcd_out_t;

endpackage

// File: hdl/slcd_stream_if.sv
interface slcd_rx_if;
  logic                valid;
  logic                ready;
  slcd_pkg::slcd_in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slcd_res_if;
  logic                valid;
  logic                ready;
  slcd_pkg::slcd_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/slcd_ram.sv
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sync_length_crc16_deframer.sv
// Input: a sync, length or CRC byte is taken without a stall; a command or payload
//   byte is loaded, then takes 8 bit steps of the serial CRC-16 register.
// Output: after the CRC high byte, each result takes a payload RAM read, then an
//   output register load that waits while a held result is not yet taken.
// Reset: synchronous, active high; clears parse phase, counters and output valid.
//   The payload RAM is not cleared; only entries written in the frame are read.
module sync_length_crc16_deframer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic              clk,
  input  logic              rst,
  slcd_rx_if.sink           rx,
  slcd_res_if.source        result
);

  localparam int KW  = $clog2(MAX_PAYLOAD + 1);
  localparam int IDXW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // parse phase codes
  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRCLO = 3'd5;
  localparam logic [2:0] PH_CRCHI = 3'd6;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CRC  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_LD   = 2'd3;

  logic [1:0]   state;
  logic [2:0]   phase;
  logic [2:0]   bit_cnt;
  logic [15:0]  crc;
  logic [7:0]   crc_lo;
  logic [7:0]   remaining;
  logic [7:0]   held_command;
  logic [KW-1:0] kept;
  logic [KW-1:0] idx;
  logic         res_err;
  logic         out_valid;
  slcd_pkg::slcd_out_t out_data;

  logic         accept;
  logic [7:0]   b;
  logic         ram_we;
  logic [7:0]   rd_data;
  logic         load;
  logic         single;
  logic         last_res;
  logic [KW-1:0] idx_inc;
  slcd_pkg::slcd_out_t res_next;

  assign accept   = rx.valid && rx.ready;
  assign b        = rx.payload.rx_byte;
  assign rx.ready = (state == ST_IDLE);

  assign ram_we = accept && !rx.payload.restart && (phase == PH_DATA)
                  && (kept < KW'(MAX_PAYLOAD));

  slcd_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (kept[IDXW-1:0]),
    .wdata (b),
    .raddr (idx[IDXW-1:0]),
    .rdata (rd_data)
  );

  assign idx_inc  = idx + KW'(1);
  assign single   = res_err || (kept == '0);
  assign last_res = single || (idx_inc == kept);
  assign load     = (state == ST_LD) && (!out_valid || result.ready);

  always_comb begin
    res_next.kind           = res_err ? slcd_pkg::KIND_ERROR : slcd_pkg::KIND_DATA;
    res_next.command        = held_command;
    res_next.payload_length = 6'(kept);
    res_next.byte_index     = single ? 5'd0 : 5'(idx);
    res_next.payload_byte   = single ? 8'd0 : rd_data;
    res_next.ack_request    = !res_err && (held_command == slcd_pkg::CMD_ACK);
    res_next.last           = last_res;
  end

  // parser and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_SYNC1;
      bit_cnt   <= '0;
      kept      <= '0;
      idx       <= '0;
      remaining <= '0;
      res_err   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (rx.payload.restart) begin
              phase <= PH_SYNC1;
            end else begin
              case (phase)
                PH_SYNC2: begin
                  if (b == slcd_pkg::SYNC2_BYTE) begin
                    phase <= PH_LEN;
                  end else if (b != slcd_pkg::SYNC1_BYTE) begin
                    phase <= PH_SYNC1;
                  end
                end
                PH_LEN: begin
                  if (b == 8'd0) begin
                    phase <= PH_SYNC1;  // malformed frame, rehunt
                  end else begin
                    remaining <= b - 8'd1;
                    kept      <= '0;
                    phase     <= PH_CMD;
                  end
                end
                PH_CMD: begin
                  phase   <= (remaining != 8'd0) ? PH_DATA : PH_CRCLO;
                  bit_cnt <= '0;
                  state   <= ST_CRC;
                end
                PH_DATA: begin
                  if (kept < KW'(MAX_PAYLOAD)) begin
                    kept <= kept + KW'(1);
                  end
                  remaining <= remaining - 8'd1;
                  if (remaining == 8'd1) begin
                    phase <= PH_CRCLO;
                  end
                  bit_cnt <= '0;
                  state   <= ST_CRC;
                end
                PH_CRCLO: begin
                  phase <= PH_CRCHI;
                end
                PH_CRCHI: begin
                  res_err <= ({b, crc_lo} != crc);
                  idx     <= '0;
                  phase   <= PH_SYNC1;
                  state   <= ST_RD;
                end
                default: begin
                  phase <= (b == slcd_pkg::SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
                end
              endcase
            end
          end
        end
        ST_CRC: begin
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_LD;  // RAM read data lands next cycle
        end
        ST_LD: begin
          if (load) begin
            if (last_res) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx_inc;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // CRC: init on length, cmd/data byte folded in, then one bit step per cycle
  always_ff @(posedge clk) begin
    if (accept && !rx.payload.restart && (state == ST_IDLE)) begin
      if (phase == PH_LEN) begin
        crc <= slcd_pkg::CRC_INIT;
      end else if (phase == PH_CMD || phase == PH_DATA) begin
        crc <= crc ^ {8'h00, b};
      end
      if (phase == PH_CMD) begin
        held_command <= b;
      end
      if (phase == PH_CRCLO) begin
        crc_lo <= b;
      end
    end else if (state == ST_CRC) begin
      crc <= crc[0] ? ((crc >> 1) ^ slcd_pkg::CRC_POLY) : (crc >> 1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  `include "sync_length_crc16_deframer_assert.svh"

  `SLCD_ASSERT_NOW(a_kept_bound, 1'b1, kept <= KW'(MAX_PAYLOAD))
  `SLCD_ASSERT_NEXT(a_run_ends_idle, load && last_res, state == ST_IDLE && out_valid)
  `SLCD_ASSERT_NOW(a_err_shape, out_valid && out_data.kind == slcd_pkg::KIND_ERROR,
    out_data.payload_byte == 8'd0 && out_data.last && !out_data.ack_request)

endmodule
